// ===== rtl/core/owb_pkg.sv =====
// Shared types, constants and helpers for the one-wire bus master.
package owb_pkg;

    localparam int TIMER_BITS = 10;
    localparam int REG_W      = 10;
    localparam int LEN_W      = ((REG_W > TIMER_BITS) ? REG_W : TIMER_BITS) + 1;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_RESET_LOW = 3'd0;
    localparam logic [2:0] REG_PRES_WAIT = 3'd1;
    localparam logic [2:0] REG_PRES_REC  = 3'd2;
    localparam logic [2:0] REG_W1_LOW    = 3'd3;
    localparam logic [2:0] REG_W1_GAP    = 3'd4;
    localparam logic [2:0] REG_W0_LOW    = 3'd5;
    localparam logic [2:0] REG_RD_LOW    = 3'd6;
    localparam logic [2:0] REG_RD_REC    = 3'd7;

    localparam logic [REG_W-1:0] RST_RESET_LOW = 10'd480;
    localparam logic [REG_W-1:0] RST_PRES_WAIT = 10'd70;
    localparam logic [REG_W-1:0] RST_PRES_REC  = 10'd70;
    localparam logic [REG_W-1:0] RST_W1_LOW    = 10'd10;
    localparam logic [REG_W-1:0] RST_W1_GAP    = 10'd45;
    localparam logic [REG_W-1:0] RST_W0_LOW    = 10'd90;
    localparam logic [REG_W-1:0] RST_RD_LOW    = 10'd1;
    localparam logic [REG_W-1:0] RST_RD_REC    = 10'd70;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [REG_W-1:0] reset_low;
        logic [REG_W-1:0] pres_wait;
        logic [REG_W-1:0] pres_rec;
        logic [REG_W-1:0] w1_low;
        logic [REG_W-1:0] w1_gap;
        logic [REG_W-1:0] w0_low;
        logic [REG_W-1:0] rd_low;
        logic [REG_W-1:0] rd_rec;
    } owb_cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } owb_res_t;

    // Length of a phase that must last at least one tick
    function automatic logic [LEN_W-1:0] len_min1(input logic [REG_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = LEN_W'(v);
        if (v == '0) begin
            r = LEN_W'(1);
        end
        return r;
    endfunction

    // Length of a phase that always adds one tick to the register
    function automatic logic [LEN_W-1:0] len_plus1(input logic [REG_W-1:0] v);
        return LEN_W'(v) + LEN_W'(1);
    endfunction

endpackage

// ===== rtl/core/one_wire_bus_master.sv =====
// The result of an accepted tick item is registered and is offered as a result item in the next cycle.
// Throughput: one item per cycle; the sequencer advances once per accepted item.
// A result register parts the channels, so a new item is taken while m_ready is high
// or the register is empty.
// Reset (aresetn low, synchronous): bus idle, state cleared, registers to defaults.
module one_wire_bus_master (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [owb_pkg::ADDR_W-1:0]  paddr,
    input  logic [owb_pkg::DATA_W-1:0]  pwdata,
    output logic [owb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [7:0]                  s_data_byte,
    input  logic [3:0]                  s_bit_count,
    input  logic                        s_bus_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_drive_low,
    output logic                        m_busy_res,
    output logic                        m_done_res,
    output logic                        m_presence,
    output logic [7:0]                  m_read_data,
    output logic                        m_rejected
);

    owb_pkg::owb_cfg_t cfg;
    owb_pkg::owb_res_t res;
    owb_pkg::owb_res_t res_reg;
    logic              m_valid_reg;
    logic              accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    owb_cfg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owb_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .cmd       (s_cmd),
        .data_byte (s_data_byte),
        .bit_count (s_bit_count),
        .bus_in    (s_bus_in),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_drive_low = res_reg.drive_low;
    assign m_busy_res  = res_reg.busy_res;
    assign m_done_res  = res_reg.done_res;
    assign m_presence  = res_reg.presence;
    assign m_read_data = res_reg.read_data;
    assign m_rejected  = res_reg.rejected;

endmodule

// ===== rtl/core/owb_cfg_regs.sv =====
// Configuration register file with APB-style access.
module owb_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [owb_pkg::ADDR_W-1:0]  paddr,
    input  logic [owb_pkg::DATA_W-1:0]  pwdata,
    output logic [owb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output owb_pkg::owb_cfg_t           cfg
);

    owb_pkg::owb_cfg_t          cfg_reg;
    logic [2:0]                 idx;
    logic [owb_pkg::REG_W-1:0]  wval;
    logic [owb_pkg::REG_W-1:0]  rval;
    logic                       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wval   = pwdata[owb_pkg::REG_W-1:0];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low <= owb_pkg::RST_RESET_LOW;
            cfg_reg.pres_wait <= owb_pkg::RST_PRES_WAIT;
            cfg_reg.pres_rec  <= owb_pkg::RST_PRES_REC;
            cfg_reg.w1_low    <= owb_pkg::RST_W1_LOW;
            cfg_reg.w1_gap    <= owb_pkg::RST_W1_GAP;
            cfg_reg.w0_low    <= owb_pkg::RST_W0_LOW;
            cfg_reg.rd_low    <= owb_pkg::RST_RD_LOW;
            cfg_reg.rd_rec    <= owb_pkg::RST_RD_REC;
        end else if (wr_en) begin
            unique case (idx)
                owb_pkg::REG_RESET_LOW: cfg_reg.reset_low <= wval;
                owb_pkg::REG_PRES_WAIT: cfg_reg.pres_wait <= wval;
                owb_pkg::REG_PRES_REC:  cfg_reg.pres_rec  <= wval;
                owb_pkg::REG_W1_LOW:    cfg_reg.w1_low    <= wval;
                owb_pkg::REG_W1_GAP:    cfg_reg.w1_gap    <= wval;
                owb_pkg::REG_W0_LOW:    cfg_reg.w0_low    <= wval;
                owb_pkg::REG_RD_LOW:    cfg_reg.rd_low    <= wval;
                default:                cfg_reg.rd_rec    <= wval;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            owb_pkg::REG_RESET_LOW: rval = cfg_reg.reset_low;
            owb_pkg::REG_PRES_WAIT: rval = cfg_reg.pres_wait;
            owb_pkg::REG_PRES_REC:  rval = cfg_reg.pres_rec;
            owb_pkg::REG_W1_LOW:    rval = cfg_reg.w1_low;
            owb_pkg::REG_W1_GAP:    rval = cfg_reg.w1_gap;
            owb_pkg::REG_W0_LOW:    rval = cfg_reg.w0_low;
            owb_pkg::REG_RD_LOW:    rval = cfg_reg.rd_low;
            default:                rval = cfg_reg.rd_rec;
        endcase
        prdata = owb_pkg::DATA_W'(rval);
    end

endmodule

// ===== rtl/core/owb_engine.sv =====
// Bus timing sequencer: advances one tick per accepted item.
module owb_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [1:0]        cmd,
    input  logic [7:0]        data_byte,
    input  logic [3:0]        bit_count,
    input  logic              bus_in,
    input  owb_pkg::owb_cfg_t cfg,
    output owb_pkg::owb_res_t res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_REC,
        PH_WR_LOW,
        PH_WR_GAP,
        PH_RD_LOW,
        PH_RD_REC
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic [owb_pkg::TIMER_BITS-1:0]   timer_reg, timer_next;
    logic [3:0]                       idx_reg, idx_next;
    logic [3:0]                       wanted_reg, wanted_next;
    logic [7:0]                       shift_reg, shift_next;
    logic [7:0]                       gath_reg, gath_next;
    logic                             pres_reg, pres_next;
    logic [owb_pkg::LEN_W-1:0]        len;
    logic                             wr_next;
    logic                             drive;
    logic                             done;
    logic                             rej;

    always_comb begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        idx_next    = idx_reg;
        wanted_next = wanted_reg;
        shift_next  = shift_reg;
        gath_next   = gath_reg;
        pres_next   = pres_reg;
        drive       = 1'b0;
        done        = 1'b0;
        rej         = 1'b0;
        wr_next     = 1'b0;
        len         = owb_pkg::LEN_W'(1);

        // Command intake: the command tick is the first tick of the operation
        if (phase_reg == PH_IDLE) begin
            timer_next = '0;
            case (cmd)
                owb_pkg::CMD_RESET: begin
                    phase_next = PH_RST_LOW;
                end
                owb_pkg::CMD_WRITE: begin
                    shift_next = data_byte;
                    idx_next   = '0;
                    phase_next = PH_WR_LOW;
                end
                owb_pkg::CMD_READ: begin
                    if (bit_count == 4'd0) begin
                        wanted_next = 4'd1;
                    end else if (bit_count > owb_pkg::BITS_PER_BYTE) begin
                        wanted_next = owb_pkg::BITS_PER_BYTE;
                    end else begin
                        wanted_next = bit_count;
                    end
                    idx_next   = '0;
                    gath_next  = '0;
                    phase_next = PH_RD_LOW;
                end
                default: ;
            endcase
        end else if (cmd != owb_pkg::CMD_TICK) begin
            rej = 1'b1;
        end

        if (phase_next != PH_IDLE) begin
            drive = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                    (phase_next == PH_RD_LOW);
            if (phase_next == PH_RST_REC && timer_next == '0) begin
                pres_next = !bus_in;
            end
            if (phase_next == PH_RD_REC && timer_next == '0 && bus_in) begin
                gath_next[idx_next[2:0]] = 1'b1;
            end

            unique case (phase_next)
                PH_RST_LOW:  len = owb_pkg::len_min1(cfg.reset_low);
                PH_RST_WAIT: len = owb_pkg::len_min1(cfg.pres_wait);
                PH_RST_REC:  len = owb_pkg::len_plus1(cfg.pres_rec);
                PH_WR_LOW:   len = shift_next[0] ? owb_pkg::len_min1(cfg.w1_low)
                                                 : owb_pkg::len_min1(cfg.w0_low);
                PH_WR_GAP:   len = owb_pkg::len_min1(cfg.w1_gap);
                PH_RD_LOW:   len = owb_pkg::len_min1(cfg.rd_low);
                PH_RD_REC:   len = owb_pkg::len_plus1(cfg.rd_rec);
                default:     len = owb_pkg::LEN_W'(1);
            endcase

            if ((owb_pkg::LEN_W'(timer_next) + owb_pkg::LEN_W'(1) >= len) ||
                (timer_next == owb_pkg::TIMER_MAX)) begin
                // End of phase: move on to the next one
                timer_next = '0;
                unique case (phase_next)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT: phase_next = PH_RST_REC;
                    PH_RST_REC: begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_WR_LOW: begin
                        if (shift_next[0] && cfg.w1_gap != '0) begin
                            phase_next = PH_WR_GAP;
                        end else begin
                            wr_next = 1'b1;
                        end
                    end
                    PH_WR_GAP:   wr_next    = 1'b1;
                    PH_RD_LOW:   phase_next = PH_RD_REC;
                    PH_RD_REC: begin
                        idx_next = idx_next + 4'd1;
                        if (idx_next >= wanted_next) begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            phase_next = PH_RD_LOW;
                        end
                    end
                    default:     phase_next = PH_IDLE;
                endcase
                if (wr_next) begin
                    shift_next = shift_next >> 1;
                    idx_next   = idx_next + 4'd1;
                    if (idx_next >= owb_pkg::BITS_PER_BYTE) begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end else begin
                        phase_next = PH_WR_LOW;
                    end
                end
            end else begin
                timer_next = timer_next + 1'b1;
            end
        end

        res.drive_low = drive;
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.presence  = pres_next;
        res.read_data = gath_next;
        res.rejected  = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            timer_reg  <= '0;
            idx_reg    <= '0;
            wanted_reg <= '0;
            shift_reg  <= '0;
            gath_reg   <= '0;
            pres_reg   <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            idx_reg    <= idx_next;
            wanted_reg <= wanted_next;
            shift_reg  <= shift_next;
            gath_reg   <= gath_next;
            pres_reg   <= pres_next;
        end
    end

endmodule

// ===== rtl/core/owb_checker.sv =====
// Port-level checks for the one-wire bus master, bound to the top level.
module owb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       pready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_drive_low,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic       m_read_data_stable_unused,
    input logic [7:0] m_read_data
);

    // Done marks the last tick, so the operation is no longer running
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done with busy still set");

    // The bus is only pulled low as part of an operation
    a_drive_in_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drive_low) |-> (m_busy_res || m_done_res))
        else $error("bus driven outside an operation");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

    // A stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_data)
                                   && $stable(m_read_data_stable_unused)))
        else $error("result item changed while stalled");

endmodule

bind one_wire_bus_master owb_checker u_owb_checker (
    .aclk                      (aclk),
    .aresetn                   (aresetn),
    .pready                    (pready),
    .m_valid                   (m_valid),
    .m_ready                   (m_ready),
    .m_drive_low               (m_drive_low),
    .m_busy_res                (m_busy_res),
    .m_done_res                (m_done_res),
    .m_read_data_stable_unused (m_rejected),
    .m_read_data               (m_read_data)
);

// ===== tb/owb_slot_checker.sv =====
// Checker for the one-wire bus master: predicts every result item and compares it.
`timescale 1ns / 1ps

module owb_slot_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [owb_pkg::ADDR_W-1:0] paddr,
    input  logic [owb_pkg::DATA_W-1:0] pwdata,
    input  logic                       pready,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic [7:0]                 s_data_byte,
    input  logic [3:0]                 s_bit_count,
    input  logic                       s_bus_in,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_drive_low,
    input  logic                       m_busy_res,
    input  logic                       m_done_res,
    input  logic                       m_presence,
    input  logic [7:0]                 m_read_data,
    input  logic                       m_rejected,
    output int                         fail_count,
    output int                         pending
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_RST_LOW, ST_RST_WAIT, ST_RST_REC,
        ST_WR_LOW, ST_WR_GAP, ST_RD_LOW, ST_RD_REC
    } seq_state_t;

    logic [owb_pkg::REG_W-1:0]      timing [8];
    seq_state_t                     st;
    logic [owb_pkg::TIMER_BITS-1:0] elapsed;
    logic [3:0]                     bit_pos;
    logic [3:0]                     bits_req;
    logic [7:0]                     tx_shift;
    logic [7:0]                     rx_bits;
    logic                           pres_flag;

    owb_pkg::owb_res_t predicted_ticks [$];

    function automatic int unsigned floor_one(input logic [owb_pkg::REG_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic int unsigned state_len();
        case (st)
            ST_RST_LOW:  return floor_one(timing[owb_pkg::REG_RESET_LOW]);
            ST_RST_WAIT: return floor_one(timing[owb_pkg::REG_PRES_WAIT]);
            ST_RST_REC:  return int'(timing[owb_pkg::REG_PRES_REC]) + 1;
            ST_WR_LOW:   return tx_shift[0] ? floor_one(timing[owb_pkg::REG_W1_LOW])
                                            : floor_one(timing[owb_pkg::REG_W0_LOW]);
            ST_WR_GAP:   return floor_one(timing[owb_pkg::REG_W1_GAP]);
            ST_RD_LOW:   return floor_one(timing[owb_pkg::REG_RD_LOW]);
            ST_RD_REC:   return int'(timing[owb_pkg::REG_RD_REC]) + 1;
            default:     return 1;
        endcase
    endfunction

    task automatic shift_out_bit(inout logic done);
        tx_shift = tx_shift >> 1;
        bit_pos  = bit_pos + 4'd1;
        if (bit_pos >= owb_pkg::BITS_PER_BYTE) begin
            st   = ST_IDLE;
            done = 1'b1;
        end else begin
            st = ST_WR_LOW;
        end
    endtask

    task automatic close_state(inout logic done);
        elapsed = '0;
        case (st)
            ST_RST_LOW:  st = ST_RST_WAIT;
            ST_RST_WAIT: st = ST_RST_REC;
            ST_RST_REC: begin
                st   = ST_IDLE;
                done = 1'b1;
            end
            ST_WR_LOW: begin
                if (tx_shift[0] && timing[owb_pkg::REG_W1_GAP] != '0) begin
                    st = ST_WR_GAP;
                end else begin
                    shift_out_bit(done);
                end
            end
            ST_WR_GAP:   shift_out_bit(done);
            ST_RD_LOW:   st = ST_RD_REC;
            ST_RD_REC: begin
                bit_pos = bit_pos + 4'd1;
                if (bit_pos >= bits_req) begin
                    st   = ST_IDLE;
                    done = 1'b1;
                end else begin
                    st = ST_RD_LOW;
                end
            end
            default:     st = ST_IDLE;
        endcase
    endtask

    // Advance the sequencer by one tick item and form its result
    task automatic step_sequencer(input logic [1:0] cmd, input logic [7:0] dbyte,
                                  input logic [3:0] bcnt, input logic bus,
                                  output owb_pkg::owb_res_t r);
        logic        rej;
        logic        done;
        logic        drv;
        logic [3:0]  n;
        int unsigned len;
        rej  = 1'b0;
        done = 1'b0;
        drv  = 1'b0;
        if (st == ST_IDLE) begin
            elapsed = '0;
            case (cmd)
                owb_pkg::CMD_RESET: st = ST_RST_LOW;
                owb_pkg::CMD_WRITE: begin
                    tx_shift = dbyte;
                    bit_pos  = '0;
                    st       = ST_WR_LOW;
                end
                owb_pkg::CMD_READ: begin
                    n = bcnt;
                    if (n == '0) n = 4'd1;
                    if (n > owb_pkg::BITS_PER_BYTE) n = owb_pkg::BITS_PER_BYTE;
                    bits_req = n;
                    bit_pos  = '0;
                    rx_bits  = '0;
                    st       = ST_RD_LOW;
                end
                default: ;
            endcase
        end else if (cmd != owb_pkg::CMD_TICK) begin
            rej = 1'b1;
        end
        if (st != ST_IDLE) begin
            drv = (st == ST_RST_LOW) || (st == ST_WR_LOW) || (st == ST_RD_LOW);
            if (st == ST_RST_REC && elapsed == '0) pres_flag = !bus;
            if (st == ST_RD_REC && elapsed == '0 && bus) rx_bits[bit_pos[2:0]] = 1'b1;
            len = state_len();
            if (int'(elapsed) + 1 >= len || elapsed == owb_pkg::TIMER_MAX) begin
                close_state(done);
            end else begin
                elapsed = elapsed + 1'b1;
            end
        end
        r.drive_low = drv;
        r.busy_res  = (st != ST_IDLE);
        r.done_res  = done;
        r.presence  = pres_flag;
        r.read_data = rx_bits;
        r.rejected  = rej;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        owb_pkg::owb_res_t r;
        if (!aresetn) begin
            timing[owb_pkg::REG_RESET_LOW] = owb_pkg::RST_RESET_LOW;
            timing[owb_pkg::REG_PRES_WAIT] = owb_pkg::RST_PRES_WAIT;
            timing[owb_pkg::REG_PRES_REC]  = owb_pkg::RST_PRES_REC;
            timing[owb_pkg::REG_W1_LOW]    = owb_pkg::RST_W1_LOW;
            timing[owb_pkg::REG_W1_GAP]    = owb_pkg::RST_W1_GAP;
            timing[owb_pkg::REG_W0_LOW]    = owb_pkg::RST_W0_LOW;
            timing[owb_pkg::REG_RD_LOW]    = owb_pkg::RST_RD_LOW;
            timing[owb_pkg::REG_RD_REC]    = owb_pkg::RST_RD_REC;
            st        = ST_IDLE;
            elapsed   = '0;
            bit_pos   = '0;
            bits_req  = '0;
            tx_shift  = '0;
            rx_bits   = '0;
            pres_flag = 1'b0;
            predicted_ticks.delete();
        end else begin
            // An item taken at the same edge as a register write still sees the old value
            if (s_valid && s_ready) begin
                step_sequencer(s_cmd, s_data_byte, s_bit_count, s_bus_in, r);
                predicted_ticks.push_back(r);
            end
            if (psel && penable && pwrite && pready) begin
                timing[paddr[owb_pkg::ADDR_W-1:2]] = pwdata[owb_pkg::REG_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (predicted_ticks.size() == 0) begin
                    $error("result item with no prediction waiting");
                    fail_count++;
                end else begin
                    r = predicted_ticks.pop_front();
                    check_field("drive_low", 8'(r.drive_low), 8'(m_drive_low));
                    check_field("busy_res",  8'(r.busy_res),  8'(m_busy_res));
                    check_field("done_res",  8'(r.done_res),  8'(m_done_res));
                    check_field("presence",  8'(r.presence),  8'(m_presence));
                    check_field("read_data", r.read_data,     m_read_data);
                    check_field("rejected",  8'(r.rejected),  8'(m_rejected));
                end
            end
        end
        pending = predicted_ticks.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the one-wire bus master testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT  = 5000;
    localparam int PRESSURE_AT  = 85;
    localparam int PRESSURE_LEN = 300;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [owb_pkg::ADDR_W-1:0] paddr;
    logic [owb_pkg::DATA_W-1:0] pwdata;
    logic [owb_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic [1:0]                 s_cmd;
    logic [7:0]                 s_data_byte;
    logic [3:0]                 s_bit_count;
    logic                       s_bus_in;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_drive_low;
    logic                       m_busy_res;
    logic                       m_done_res;
    logic                       m_presence;
    logic [7:0]                 m_read_data;
    logic                       m_rejected;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    logic last_busy;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    one_wire_bus_master i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .s_bit_count (s_bit_count),
        .s_bus_in    (s_bus_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive_low (m_drive_low),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_presence  (m_presence),
        .m_read_data (m_read_data),
        .m_rejected  (m_rejected)
    );

    owb_slot_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .s_bit_count (s_bit_count),
        .s_bus_in    (s_bus_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive_low (m_drive_low),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_presence  (m_presence),
        .m_read_data (m_read_data),
        .m_rejected  (m_rejected),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Mostly short gaps, a few long ones; none in quiet stretches
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Entered and left at a falling edge; valid stays high for a back-to-back item
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] dbyte,
                             input logic [3:0] bcnt, input logic bus);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= dbyte;
        s_bit_count <= bcnt;
        s_bus_in    <= bus;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random(input int count);
        logic [1:0] cmd;
        repeat (count) begin
            cmd = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : owb_pkg::CMD_TICK;
            send_item(cmd, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Tick until the result shows the sequencer idle and nothing is outstanding
    task automatic run_until_idle();
        int guard;
        guard = 0;
        do begin
            send_item(owb_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            s_valid <= 1'b0;
            wait (pending == 0);
            @(negedge aclk);
            guard++;
        end while (last_busy && guard < 20000);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [owb_pkg::REG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= owb_pkg::DATA_W'(val);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_timings(input int lo, input int hi);
        repeat (2) @(negedge aclk);
        for (int i = 0; i < 8; i++) begin
            apb_write(3'(i), owb_pkg::REG_W'($urandom_range(lo, hi)));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: random back-pressure, with one long hold-off to fill the block
    initial begin
        int stall;
        int results_seen;
        results_seen = 0;
        m_ready   = 1'b0;
        last_busy = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = (results_seen == PRESSURE_AT) ? PRESSURE_LEN : pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            last_busy = m_busy_res;
            results_seen++;
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("** one_wire_bus_master: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_cmd       = owb_pkg::CMD_TICK;
        s_data_byte = '0;
        s_bit_count = '0;
        s_bus_in    = 1'b1;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // reset timings: a single-bit read
        send_item(owb_pkg::CMD_READ, 8'hA5, 4'd1, 1'b1);
        run_until_idle();

        // every length zero: lows act as one tick, the one-bit gap is skipped
        set_timings(0, 0);
        send_item(owb_pkg::CMD_TICK, 8'hFF, 4'hF, 1'b1);
        send_item(owb_pkg::CMD_RESET, 8'h00, 4'd0, 1'b0);
        repeat (2) send_item(owb_pkg::CMD_TICK, 8'h00, 4'd0, 1'b0);
        send_item(owb_pkg::CMD_RESET, 8'hFF, 4'hF, 1'b1);
        repeat (2) send_item(owb_pkg::CMD_TICK, 8'hFF, 4'hF, 1'b1);
        send_item(owb_pkg::CMD_WRITE, 8'hFF, 4'd0, 1'b1);
        repeat (3) send_item(owb_pkg::CMD_TICK, 8'h00, 4'd0, 1'b0);
        // command while busy: flag it and run on
        send_item(owb_pkg::CMD_READ, 8'h00, 4'd8, 1'b1);
        repeat (3) send_item(owb_pkg::CMD_TICK, 8'h00, 4'd0, 1'b0);
        // bit count of zero reads one bit, above eight reads eight
        send_item(owb_pkg::CMD_READ, 8'h00, 4'd0, 1'b1);
        send_item(owb_pkg::CMD_TICK, 8'h00, 4'd0, 1'b1);
        for (int i = 0; i < 16; i++) begin
            send_item((i == 0) ? owb_pkg::CMD_READ : owb_pkg::CMD_TICK, 8'h00, 4'hF,
                      1'(i >> 1));
        end
        run_until_idle();

        for (int p = 0; p < 6; p++) begin
            quiet = (p % 3 == 2);
            set_timings(0, (p == 4) ? 20 : 6);
            send_random(35);
            run_until_idle();
        end
        quiet = 1'b0;

        // longest recovery: a read slot runs the timer to its top
        set_timings(1, 1);
        apb_write(owb_pkg::REG_RD_REC, owb_pkg::REG_W'(1023));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        send_item(owb_pkg::CMD_READ, 8'h5A, 4'd1, 1'b1);
        run_until_idle();

        set_timings(1, 1);
        send_random(35);
        run_until_idle();

        wait (pending == 0);
        repeat (4) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("** one_wire_bus_master: PASSED **");
        end else begin
            $display("** one_wire_bus_master: FAILED **");
        end
        $finish;
    end

endmodule
